[design/jpeg_dequant_idct_8x8_assert.svh]
// assertion macros used by the checker file
`ifndef JPEG_DEQUANT_IDCT_8X8_ASSERT_SVH
`define JPEG_DEQUANT_IDCT_8X8_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JDI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jdi check failed");

// next-cycle implication, disabled during reset
`define JDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jdi check failed");

`endif

[design/jdi_pkg.sv]
// shared types, constants and table builders for the dequantizing idct
`timescale 1ns / 1ps
package jdi_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int WORD_W = 56;
  localparam int COEF_W = 16;
  localparam int QRAW_W = 16;
  localparam int PAIR_W = 32;
  localparam longint unsigned Billion = 64'd1000000000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [7:0] vec_t;
  typedef logic [PAIR_W-1:0] pair_tab_t [64];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_WRITE,
    ST_EMIT
  } state_e;

  // aan row and column factors, times 10^9
  function automatic logic [63:0] aan_dec(input int k);
    case (k)
      0: return 64'd1000000000;
      1: return 64'd1387039845;
      2: return 64'd1306562965;
      3: return 64'd1175875602;
      4: return 64'd1000000000;
      5: return 64'd785694958;
      6: return 64'd541196100;
      default: return 64'd275899379;
    endcase
  endfunction

  // round a decimal constant (times 10^9) to the given fraction bits
  function automatic logic [63:0] fix_dec(input logic [63:0] d, input int f);
    return ((d << f) + 64'd500000000) / Billion;
  endfunction

  // pair factor per table position, 30 fraction bits
  function automatic pair_tab_t gen_pair();
    pair_tab_t t;
    logic [63:0] sx;
    logic [63:0] sy;
    for (int p = 0; p < 64; p++) begin
      sx = fix_dec(aan_dec(p % 8), 30);
      sy = fix_dec(aan_dec(p / 8), 30);
      t[p] = PAIR_W'((sx * sy + (64'd1 << 29)) >> 30);
    end
    return t;
  endfunction

endpackage

[design/jdi_aan_1d.sv]
// four-stage pipelined aan one-dimensional inverse transform
`timescale 1ns / 1ps
module jdi_aan_1d import jdi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  vec_t vec_i,
  output vec_t vec_o
);

  localparam int KW = FRAC_BITS + 2;
  localparam logic [KW-1:0] KSqrt2 = KW'(fix_dec(64'd1414213562, FRAC_BITS));
  localparam logic [KW-1:0] K2c2 = KW'(fix_dec(64'd1847759065, FRAC_BITS));
  localparam logic [KW-1:0] KC2mc6 = KW'(fix_dec(64'd1082392200, FRAC_BITS));
  localparam logic [KW-1:0] KC2pc6 = KW'(fix_dec(64'd2613125930, FRAC_BITS));

  // floored product with a positive constant
  function automatic word_t mulc(input word_t a, input logic [KW-1:0] k);
    logic signed [WORD_W+KW:0] p;
    p = a * $signed({1'b0, k});
    return p[FRAC_BITS +: WORD_W];
  endfunction

  word_t t10_q, t11_q, t13_q, a26_q, z10_q, z11_q, z12_q, z13_q, b_q, e_q;
  word_t s2_t10_q, s2_t11_q, s2_t13_q, t7_q, m1_q, u11_q, z5_q, m2_q, m3_q;
  word_t t0_q, t1_q, t2_q, t3_q, t6_q, u10_q, s3_t7_q, s3_u11_q;

  // stage 1: butterflies
  always_ff @(posedge clk_i) begin
    t10_q <= vec_i[0] + vec_i[4];
    t11_q <= vec_i[0] - vec_i[4];
    t13_q <= vec_i[2] + vec_i[6];
    a26_q <= vec_i[2] - vec_i[6];
    z13_q <= vec_i[5] + vec_i[3];
    z10_q <= vec_i[5] - vec_i[3];
    z11_q <= vec_i[1] + vec_i[7];
    z12_q <= vec_i[1] - vec_i[7];
    b_q   <= (vec_i[1] + vec_i[7]) - (vec_i[5] + vec_i[3]);
    e_q   <= (vec_i[5] - vec_i[3]) + (vec_i[1] - vec_i[7]);
  end

  // stage 2: constant products
  always_ff @(posedge clk_i) begin
    s2_t10_q <= t10_q;
    s2_t11_q <= t11_q;
    s2_t13_q <= t13_q;
    t7_q     <= z11_q + z13_q;
    m1_q     <= mulc(a26_q, KSqrt2);
    u11_q    <= mulc(b_q, KSqrt2);
    z5_q     <= mulc(e_q, K2c2);
    m2_q     <= mulc(z12_q, KC2mc6);
    m3_q     <= mulc(-z10_q, KC2pc6);
  end

  // stage 3: even part and odd terms
  always_ff @(posedge clk_i) begin
    t0_q     <= s2_t10_q + s2_t13_q;
    t3_q     <= s2_t10_q - s2_t13_q;
    t1_q     <= s2_t11_q + (m1_q - s2_t13_q);
    t2_q     <= s2_t11_q - (m1_q - s2_t13_q);
    t6_q     <= (m3_q + z5_q) - t7_q;
    u10_q    <= m2_q - z5_q;
    s3_t7_q  <= t7_q;
    s3_u11_q <= u11_q;
  end

  // stage 4: output butterflies
  always_ff @(posedge clk_i) begin
    vec_o[0] <= t0_q + s3_t7_q;
    vec_o[7] <= t0_q - s3_t7_q;
    vec_o[1] <= t1_q + t6_q;
    vec_o[6] <= t1_q - t6_q;
    vec_o[2] <= t2_q + (s3_u11_q - t6_q);
    vec_o[5] <= t2_q - (s3_u11_q - t6_q);
    vec_o[4] <= t3_q + (u10_q + (s3_u11_q - t6_q));
    vec_o[3] <= t3_q - (u10_q + (s3_u11_q - t6_q));
  end

endmodule

[design/jpeg_dequant_idct_8x8.sv]
// top level of the dequantizing 8x8 aan inverse dct
// Usage: an item is transferred when start_i is high and busy_o is low.
// action_i = 0 loads quant table entry position_i with quant_value_i; it is
// scaled by the aan row and column factors on the way into the table memory.
// action_i = 1 delivers the next coefficient of the block in row-major order;
// a block streams in at one coefficient per cycle.
// On the 64th coefficient busy_o rises and the transform runs: for each of
// the eight columns, eight memory reads, a pass through the four-stage
// 1-d unit and 8 workspace writes; then for each row eight reads, a pass
// through the 1-d unit and an emit of the row. The passes run one after
// another on the shared 1-d unit, and no new item is taken until it is done.
// Each row appears on pixel_*_o, row_index_o and last_row_o for one cycle
// with valid_o high; last_row_o marks row 7.
// The receiver cannot stall; results are never held.
// Reset clears the sequencer and the coefficient count; the table,
// coefficient and workspace memories hold garbage until written.
`timescale 1ns / 1ps
module jpeg_dequant_idct_8x8 import jdi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              action_i,
  input  logic [5:0]        position_i,
  input  logic [QRAW_W-1:0] quant_value_i,
  input  logic [COEF_W-1:0] coefficient_i,
  output logic              valid_o,
  output logic [7:0]        pixel_0_o,
  output logic [7:0]        pixel_1_o,
  output logic [7:0]        pixel_2_o,
  output logic [7:0]        pixel_3_o,
  output logic [7:0]        pixel_4_o,
  output logic [7:0]        pixel_5_o,
  output logic [7:0]        pixel_6_o,
  output logic [7:0]        pixel_7_o,
  output logic [2:0]        row_index_o,
  output logic              last_row_o
);

  localparam int QW = 18 + FRAC_BITS;
  localparam int QP_W = QRAW_W + PAIR_W;
  localparam pair_tab_t PairTab = gen_pair();
  localparam int WaitLast = 5;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] lane_q, lane_d;
  logic       col_q, col_d;
  logic [5:0] count_q, count_d;
  logic       rd_v_q;
  logic [2:0] rd_k_q;

  logic [QW-1:0]     quant_mem [64];
  logic [COEF_W-1:0] coef_mem [64];
  word_t             ws_mem [64];
  logic [QW-1:0]     quant_rd_q;
  logic [COEF_W-1:0] coef_rd_q;
  word_t             ws_rd_q;

  logic       accept;
  logic [5:0] rd_addr;
  logic [5:0] wr_addr;
  logic       rd_en;
  logic       ws_we;
  logic       emit;
  logic [QP_W-1:0] qp;
  vec_t       vec_q;
  vec_t       res;
  logic [7:0] pix [8];

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign rd_addr = col_q ? {cnt_q[2:0], lane_q} : {lane_q, cnt_q[2:0]};
  assign wr_addr = {cnt_q[2:0], lane_q};
  assign rd_en = (state_q == ST_READ) && !cnt_q[3];
  assign ws_we = (state_q == ST_WRITE);
  assign emit = (state_q == ST_EMIT);

  // scaled quant entry
  assign qp = QP_W'(quant_value_i) * QP_W'(PairTab[position_i])
    + (QP_W'(1) << (29 - FRAC_BITS));

  // table and coefficient memories
  always_ff @(posedge clk_i) begin
    if (accept && !action_i) begin
      quant_mem[position_i] <= qp[30-FRAC_BITS +: QW];
    end
    if (accept && action_i) begin
      coef_mem[count_q] <= coefficient_i;
    end
    quant_rd_q <= quant_mem[rd_addr];
    coef_rd_q <= coef_mem[rd_addr];
  end

  // column workspace memory
  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem[wr_addr] <= res[cnt_q[2:0]];
    end
    ws_rd_q <= ws_mem[rd_addr];
  end

  // read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      rd_k_q <= '0;
    end else begin
      rd_v_q <= rd_en;
      rd_k_q <= cnt_q[2:0];
    end
  end

  // operand vector, dequantized on the column pass
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (col_q) begin
        vec_q[rd_k_q] <= $signed(coef_rd_q) * $signed({1'b0, quant_rd_q});
      end else begin
        vec_q[rd_k_q] <= ws_rd_q;
      end
    end
  end

  jdi_aan_1d #(
    .FRAC_BITS(FRAC_BITS)
  ) u_aan (
    .clk_i(clk_i),
    .vec_i(vec_q),
    .vec_o(res)
  );

  // descale, level shift and clamp
  function automatic logic [7:0] to_pixel(input word_t x);
    word_t s;
    s = (x >>> (FRAC_BITS + 3)) + WORD_W'(128);
    if (s < 0) begin
      return 8'd0;
    end else if (s > WORD_W'(255)) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pix[k] = to_pixel(res[k]);
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      lane_q  <= '0;
      col_q   <= 1'b1;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lane_q  <= lane_d;
      col_q   <= col_d;
      count_q <= count_d;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lane_d  = lane_q;
    col_d   = col_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && action_i) begin
          count_d = count_q + 6'd1;
          if (count_q == 6'd63) begin
            state_d = ST_READ;
            cnt_d   = '0;
            lane_d  = '0;
            col_d   = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (cnt_q == 4'd8) begin
          state_d = ST_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_WAIT: begin
        if (cnt_q == 4'(WaitLast)) begin
          state_d = col_q ? ST_WRITE : ST_EMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_WRITE: begin
        if (cnt_q == 4'd7) begin
          cnt_d   = '0;
          lane_d  = lane_q + 3'd1;
          state_d = ST_READ;
          if (lane_q == 3'd7) begin
            col_d = 1'b0;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_EMIT: begin
        cnt_d  = '0;
        lane_d = lane_q + 3'd1;
        state_d = (lane_q == 3'd7) ? ST_IDLE : ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_0_o   <= pix[0];
      pixel_1_o   <= pix[1];
      pixel_2_o   <= pix[2];
      pixel_3_o   <= pix[3];
      pixel_4_o   <= pix[4];
      pixel_5_o   <= pix[5];
      pixel_6_o   <= pix[6];
      pixel_7_o   <= pix[7];
      row_index_o <= lane_q;
      last_row_o  <= (lane_q == 3'd7);
    end
  end

endmodule

[design/jdi_checker.sv]
// port-level checks for the dequantizing idct, bound to the top level
`timescale 1ns / 1ps
`include "jpeg_dequant_idct_8x8_assert.svh"
module jdi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       action_i,
  input logic       valid_o,
  input logic [2:0] row_index_o,
  input logic       last_row_o
);

  // rows before the last come while the block is still busy
  `JDI_ASSERT_NOW(a_row_busy, valid_o && !last_row_o, busy_o)
  // the last row is row seven
  `JDI_ASSERT_NOW(a_last_seven, valid_o && last_row_o, row_index_o == 3'd7)
  // rows never come back to back
  `JDI_ASSERT_NEXT(a_row_gap, valid_o, !valid_o)
  // a transform only starts after a coefficient transfer
  `JDI_ASSERT_NOW(a_busy_cause, $rose(busy_o), $past(start_i && action_i))

endmodule

bind jpeg_dequant_idct_8x8 jdi_checker u_jdi_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start_i(start_i),
  .busy_o(busy_o),
  .action_i(action_i),
  .valid_o(valid_o),
  .row_index_o(row_index_o),
  .last_row_o(last_row_o)
);
